// ----- sv/lbc_pkg.sv -----
// Shared types, constants and register codes for the layer blend compositor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

    localparam int LBC_LAYER_COUNT = 4;
    localparam int LBC_LAYERS_MAX  = 4;
    localparam int LBC_CHANNELS    = 3;

    localparam logic [7:0] BACKGROUND   = 8'd255;
    localparam logic [6:0] FULL_OPACITY = 7'd100;

    // x / 100 as (x * 5243) >> 19, exact for x up to 25500
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_MULTIPLY   = 3'd1;
    localparam logic [2:0] MODE_DARKEN     = 3'd2;
    localparam logic [2:0] MODE_LIGHTEN    = 3'd3;
    localparam logic [2:0] MODE_DIFFERENCE = 3'd4;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_MODES  = 3'd1;
    localparam logic [2:0] REG_OP0    = 3'd2;
    localparam logic [2:0] REG_OP1    = 3'd3;
    localparam logic [2:0] REG_OP2    = 3'd4;
    localparam logic [2:0] REG_OP3    = 3'd5;

    localparam logic [3:0]  ENABLE_RESET = 4'hF;
    localparam logic [11:0] MODES_RESET  = 12'h000;

    typedef logic [LBC_CHANNELS-1:0][7:0]   t_chan_vec;
    typedef t_chan_vec [LBC_LAYERS_MAX-1:0] t_pix;

    typedef struct packed {
        logic [LBC_LAYERS_MAX-1:0]      layer_enable;
        logic [3*LBC_LAYERS_MAX-1:0]    layer_modes;
        logic [LBC_LAYERS_MAX-1:0][6:0] opacity;
    } t_cfg;

    typedef struct packed {
        logic       on;
        logic [2:0] mode;
        logic [6:0] op;
    } t_layer_cfg;

endpackage

`default_nettype wire

// ----- sv/lbc_if.sv -----
// Valid/ready channel interfaces for the compositor input and output words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] l0_ch0;
    logic [7:0] l0_ch1;
    logic [7:0] l0_ch2;
    logic [7:0] l1_ch0;
    logic [7:0] l1_ch1;
    logic [7:0] l1_ch2;
    logic [7:0] l2_ch0;
    logic [7:0] l2_ch1;
    logic [7:0] l2_ch2;
    logic [7:0] l3_ch0;
    logic [7:0] l3_ch1;
    logic [7:0] l3_ch2;

    modport source (
        output valid, l0_ch0, l0_ch1, l0_ch2, l1_ch0, l1_ch1, l1_ch2,
               l2_ch0, l2_ch1, l2_ch2, l3_ch0, l3_ch1, l3_ch2,
        input  ready
    );
    modport sink (
        input  valid, l0_ch0, l0_ch1, l0_ch2, l1_ch0, l1_ch1, l1_ch2,
               l2_ch0, l2_ch1, l2_ch2, l3_ch0, l3_ch1, l3_ch2,
        output ready
    );
endinterface

interface lbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;

    modport source (output valid, out_ch0, out_ch1, out_ch2, input ready);
    modport sink   (input valid, out_ch0, out_ch1, out_ch2, output ready);
endinterface

`default_nettype wire

// ----- sv/layer_blend_compositor_unit.sv -----
// Top level of the layer blend compositor: config registers, layer chain,
// output register. Depends on lbc_pkg, lbc_if, lbc_cfg_regs, lbc_layer_stage.
`timescale 1ns / 1ps
`default_nettype none

// Composites up to four layer pixels (three channels each) over a white
// background, layer 0 first, with per-layer blend mode and opacity.
// Accepts one pixel word per clock and returns one word per pixel, in order.
// Each layer is a three-stage pipeline (blend, opacity mix, divide by 100)
// with the three channels in parallel lanes, followed by the output
// register. The whole chain stalls only when the output register holds a
// word that the sink does not take. Configuration registers (layer_enable,
// layer_modes, opacity_layer0..3 at byte addresses 0,4,..,20) must be
// written only while no pixel is in flight; the block does not enforce it.
module layer_blend_compositor_unit #(
    parameter int LAYER_COUNT = lbc_pkg::LBC_LAYER_COUNT
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lbc_in_if.sink       i_pix,
    lbc_out_if.source    o_pix,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    lbc_pkg::t_cfg      cfg;
    logic               en;
    logic               [LAYER_COUNT:0] st_valid;
    lbc_pkg::t_pix      [LAYER_COUNT:0] st_pix;
    lbc_pkg::t_chan_vec [LAYER_COUNT:0] st_dst;
    logic               r_out_valid;
    lbc_pkg::t_chan_vec r_out;

    lbc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign en          = !r_out_valid || o_pix.ready;
    assign i_pix.ready = en;

    assign st_valid[0] = i_pix.valid;
    assign st_pix[0]   = {i_pix.l3_ch2, i_pix.l3_ch1, i_pix.l3_ch0,
                          i_pix.l2_ch2, i_pix.l2_ch1, i_pix.l2_ch0,
                          i_pix.l1_ch2, i_pix.l1_ch1, i_pix.l1_ch0,
                          i_pix.l0_ch2, i_pix.l0_ch1, i_pix.l0_ch0};
    assign st_dst[0]   = {lbc_pkg::LBC_CHANNELS{lbc_pkg::BACKGROUND}};

    for (genvar k = 0; k < LAYER_COUNT; k++) begin : g_layer
        lbc_pkg::t_layer_cfg lcfg;

        assign lcfg.on   = cfg.layer_enable[k];
        assign lcfg.mode = cfg.layer_modes[3*k +: 3];
        assign lcfg.op   = cfg.opacity[k];

        lbc_layer_stage #(
            .LAYER (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_lcfg  (lcfg),
            .i_valid (st_valid[k]),
            .i_pix   (st_pix[k]),
            .i_dst   (st_dst[k]),
            .o_valid (st_valid[k+1]),
            .o_pix   (st_pix[k+1]),
            .o_dst   (st_dst[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= st_valid[LAYER_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && st_valid[LAYER_COUNT]) begin
            r_out <= st_dst[LAYER_COUNT];
        end
    end

    assign o_pix.valid   = r_out_valid;
    assign o_pix.out_ch0 = r_out[0];
    assign o_pix.out_ch1 = r_out[1];
    assign o_pix.out_ch2 = r_out[2];

endmodule

`default_nettype wire

// ----- sv/lbc_cfg_regs.sv -----
// APB-style configuration registers: layer enables, modes and opacities.
// Depends on lbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbc_cfg_regs (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [4:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output lbc_pkg::t_cfg     o_cfg
);

    logic [2:0]    idx;
    logic          wr;
    logic [6:0]    op_sat;
    logic [1:0]    op_sel;
    lbc_pkg::t_cfg r_cfg;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign op_sat = (pwdata[6:0] > lbc_pkg::FULL_OPACITY) ? lbc_pkg::FULL_OPACITY
                                                          : pwdata[6:0];
    assign op_sel = 2'(idx - lbc_pkg::REG_OP0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layer_enable <= lbc_pkg::ENABLE_RESET;
            r_cfg.layer_modes  <= lbc_pkg::MODES_RESET;
            for (int k = 0; k < lbc_pkg::LBC_LAYERS_MAX; k++) begin
                r_cfg.opacity[k] <= lbc_pkg::FULL_OPACITY;
            end
        end else if (wr) begin
            if (idx == lbc_pkg::REG_ENABLE) begin
                r_cfg.layer_enable <= pwdata[3:0];
            end else if (idx == lbc_pkg::REG_MODES) begin
                r_cfg.layer_modes <= pwdata[11:0];
            end else if (idx inside {[lbc_pkg::REG_OP0:lbc_pkg::REG_OP3]}) begin
                r_cfg.opacity[op_sel] <= op_sat;
            end
        end
    end

    always_comb begin
        case (idx)
            lbc_pkg::REG_ENABLE: prdata = {28'd0, r_cfg.layer_enable};
            lbc_pkg::REG_MODES:  prdata = {20'd0, r_cfg.layer_modes};
            lbc_pkg::REG_OP0:    prdata = {25'd0, r_cfg.opacity[0]};
            lbc_pkg::REG_OP1:    prdata = {25'd0, r_cfg.opacity[1]};
            lbc_pkg::REG_OP2:    prdata = {25'd0, r_cfg.opacity[2]};
            lbc_pkg::REG_OP3:    prdata = {25'd0, r_cfg.opacity[3]};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/lbc_blend_lane.sv -----
// One channel lane of a layer: mode blend, opacity mix, divide by 100.
// Three register stages. Depends on lbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbc_blend_lane (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  lbc_pkg::t_layer_cfg    i_lcfg,
    input  wire  [7:0]             i_src,
    input  wire  [7:0]             i_dst,
    output logic [7:0]             o_res
);

    logic [15:0] mul;
    logic [7:0]  n_b;
    logic [7:0]  r_b;
    logic [7:0]  r_dst1;
    logic [6:0]  op_inv;
    logic [14:0] n_sum;
    logic [14:0] r_sum;
    logic [7:0]  r_dst2;
    logic [27:0] quot_prod;
    logic [7:0]  n_res;
    logic [7:0]  r_res;

    assign mul = 16'(i_src) * 16'(i_dst);

    always_comb begin
        case (i_lcfg.mode)
            lbc_pkg::MODE_MULTIPLY:   n_b = mul[15:8];
            lbc_pkg::MODE_DARKEN:     n_b = (i_src < i_dst) ? i_src : i_dst;
            lbc_pkg::MODE_LIGHTEN:    n_b = (i_src > i_dst) ? i_src : i_dst;
            lbc_pkg::MODE_DIFFERENCE: n_b = (i_src > i_dst) ? 8'(i_src - i_dst)
                                                            : 8'(i_dst - i_src);
            default:                  n_b = i_src;
        endcase
    end

    assign op_inv = 7'(lbc_pkg::FULL_OPACITY - i_lcfg.op);
    assign n_sum  = 15'(15'(i_lcfg.op) * 15'(r_b)) + 15'(15'(op_inv) * 15'(r_dst1));

    assign quot_prod = 28'(r_sum) * 28'(lbc_pkg::DIV100_MUL);
    assign n_res     = i_lcfg.on ? 8'(quot_prod >> lbc_pkg::DIV100_SHIFT) : r_dst2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b    <= n_b;
            r_dst1 <= i_dst;
            r_sum  <= n_sum;
            r_dst2 <= r_dst1;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ----- sv/lbc_layer_stage.sv -----
// One layer of the compositing chain: three channel lanes plus the
// valid and pixel words carried alongside. Depends on lbc_pkg, lbc_blend_lane.
`timescale 1ns / 1ps
`default_nettype none

module lbc_layer_stage #(
    parameter int LAYER = 0
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_en,
    input  lbc_pkg::t_layer_cfg    i_lcfg,
    input  wire                    i_valid,
    input  lbc_pkg::t_pix          i_pix,
    input  lbc_pkg::t_chan_vec     i_dst,
    output logic                   o_valid,
    output lbc_pkg::t_pix          o_pix,
    output lbc_pkg::t_chan_vec     o_dst
);

    localparam int DEPTH = 3;

    logic          [DEPTH-1:0] r_valid;
    lbc_pkg::t_pix [DEPTH-1:0] r_pix;

    for (genvar c = 0; c < lbc_pkg::LBC_CHANNELS; c++) begin : g_lane
        lbc_blend_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_lcfg (i_lcfg),
            .i_src  (i_pix[LAYER][c]),
            .i_dst  (i_dst[c]),
            .o_res  (o_dst[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= {r_pix[DEPTH-2:0], i_pix};
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_pix   = r_pix[DEPTH-1];

endmodule

`default_nettype wire
